>>> sv/tas_pkg.sv
`default_nettype none

package tas_pkg;

    localparam int TASK_COUNT_DEF  = 2;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int TASK_MAX   = 2;
    localparam int LIMIT_W    = 16;
    localparam int ACTION_W   = 2;
    localparam int PERIOD_W   = 10;
    localparam int TRIGGER_W  = 16;
    localparam int MODE_W     = 2;
    localparam int MARK_W     = 2;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    // manager states
    localparam logic [MODE_W-1:0] MODE_NORMAL     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TIMEOUT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESET_EXEC = 2'd2;

    // per-task supervision marks
    localparam logic [MARK_W-1:0] MARK_IDLE    = 2'd0;
    localparam logic [MARK_W-1:0] MARK_READY   = 2'd1;
    localparam logic [MARK_W-1:0] MARK_TIMEOUT = 2'd2;

    // timeout actions
    localparam logic [ACTION_W-1:0] ACT_NOTHING     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POWER_RESET = 2'd1;

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_ALIVE = 1'b1;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_LIMIT_0  = 3'd0;
    localparam logic [2:0] REG_LIMIT_1  = 3'd1;
    localparam logic [2:0] REG_ACTION_0 = 3'd2;
    localparam logic [2:0] REG_ACTION_1 = 3'd3;
    localparam logic [2:0] REG_PERIOD   = 3'd4;
    localparam logic [2:0] REG_TRIGGER  = 3'd5;

    typedef struct packed {
        logic [TASK_MAX-1:0][LIMIT_W-1:0]  limit;
        logic [TASK_MAX-1:0][ACTION_W-1:0] action;
        logic [PERIOD_W-1:0]               tick_period;
        logic [TRIGGER_W-1:0]              trigger_value;
    } cfg_t;

endpackage

`default_nettype wire

>>> sv/tas_ifs.sv
`default_nettype none

interface tas_req_if;
    logic valid;
    logic ready;
    logic req_type;
    logic task_index;

    modport source (output valid, output req_type, output task_index, input ready);
    modport sink   (input valid, input req_type, input task_index, output ready);
endinterface

interface tas_res_if;
    logic        valid;
    logic        ready;
    logic        trigger_write;
    logic [15:0] trigger_out;
    logic        timeout_report;
    logic [1:0]  manager_mode;
    logic [1:0]  timed_out_mask;

    modport source (output valid, output trigger_write, output trigger_out,
                    output timeout_report, output manager_mode, output timed_out_mask,
                    input ready);
    modport sink   (input valid, input trigger_write, input trigger_out,
                    input timeout_report, input manager_mode, input timed_out_mask,
                    output ready);
endinterface

`default_nettype wire

>>> sv/tas_cfg_regs.sv
`default_nettype none

module tas_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tas_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tas_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tas_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output tas_pkg::cfg_t                     cfg
);

    tas_pkg::cfg_t cfg_reg;
    tas_pkg::cfg_t cfg_next;
    logic [2:0]    reg_index;
    logic          wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                tas_pkg::REG_LIMIT_0:  cfg_next.limit[0] = pwdata[tas_pkg::LIMIT_W-1:0];
                tas_pkg::REG_LIMIT_1:  cfg_next.limit[1] = pwdata[tas_pkg::LIMIT_W-1:0];
                tas_pkg::REG_ACTION_0: cfg_next.action[0] = pwdata[tas_pkg::ACTION_W-1:0];
                tas_pkg::REG_ACTION_1: cfg_next.action[1] = pwdata[tas_pkg::ACTION_W-1:0];
                tas_pkg::REG_PERIOD:   cfg_next.tick_period = pwdata[tas_pkg::PERIOD_W-1:0];
                tas_pkg::REG_TRIGGER:  cfg_next.trigger_value = pwdata[tas_pkg::TRIGGER_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit         <= {tas_pkg::TASK_MAX{{tas_pkg::LIMIT_W{1'b1}}}};
            cfg_reg.action        <= {tas_pkg::TASK_MAX{tas_pkg::ACT_NOTHING}};
            cfg_reg.tick_period   <= tas_pkg::PERIOD_W'(1);
            cfg_reg.trigger_value <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            tas_pkg::REG_LIMIT_0:  prdata = tas_pkg::PDATA_W'(cfg_reg.limit[0]);
            tas_pkg::REG_LIMIT_1:  prdata = tas_pkg::PDATA_W'(cfg_reg.limit[1]);
            tas_pkg::REG_ACTION_0: prdata = tas_pkg::PDATA_W'(cfg_reg.action[0]);
            tas_pkg::REG_ACTION_1: prdata = tas_pkg::PDATA_W'(cfg_reg.action[1]);
            tas_pkg::REG_PERIOD:   prdata = tas_pkg::PDATA_W'(cfg_reg.tick_period);
            tas_pkg::REG_TRIGGER:  prdata = tas_pkg::PDATA_W'(cfg_reg.trigger_value);
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/task_alive_supervisor.sv
// Task alive supervisor.
// Requests arrive on the req channel (valid/ready): req_type 0 is a periodic
// tick, 1 is an alive report from task task_index. Each accepted request
// yields exactly one response on the res channel, registered, in the cycle
// after acceptance: trigger write strobe and value, timeout report, the
// manager mode after the request and the timed-out task mask.
// Throughput is one request per cycle while res.ready is high; all
// per-task saturating adds and limit compares sit between the supervision
// state registers and the response register, so the path is one add and
// one compare per task. A stalled response (res.ready low) holds in its
// register; the next request is still taken in that cycle only if the
// response is consumed, so req.ready = !res.valid || res.ready.
// Reset clears all tasks to unsupervised, counts to zero and the manager
// to normal; registers take their documented reset values.
// Registers are written over the APB port at byte address 4 * index.
`default_nettype none

module task_alive_supervisor #(
    parameter int TASK_COUNT  = tas_pkg::TASK_COUNT_DEF,
    parameter int COUNT_WIDTH = tas_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tas_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tas_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tas_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    tas_req_if.sink                           req,
    tas_res_if.source                         res
);

    localparam int SUM_W = ((COUNT_WIDTH > tas_pkg::PERIOD_W) ?
                            COUNT_WIDTH : tas_pkg::PERIOD_W) + 1;
    localparam int CMP_W = (COUNT_WIDTH > tas_pkg::LIMIT_W) ?
                           COUNT_WIDTH : tas_pkg::LIMIT_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    tas_pkg::cfg_t cfg;

    tas_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // supervision state
    logic [tas_pkg::MODE_W-1:0]                     mode_reg, mode_next;
    logic [tas_pkg::ACTION_W-1:0]                   action_reg, action_next;
    logic [TASK_COUNT-1:0][tas_pkg::MARK_W-1:0]     mark_reg, mark_next;
    logic [TASK_COUNT-1:0][COUNT_WIDTH-1:0]         elapsed_reg, elapsed_next;
    logic [COUNT_WIDTH-1:0]                         rst_elapsed_reg, rst_elapsed_next;

    // response register
    logic                           res_valid_reg, res_valid_next;
    logic                           trig_write_reg, trig_write_next;
    logic [tas_pkg::TRIGGER_W-1:0]  trig_out_reg, trig_out_next;
    logic                           report_reg, report_next;
    logic [tas_pkg::MODE_W-1:0]     mode_out_reg;
    logic [tas_pkg::TASK_MAX-1:0]   mask_reg, mask_next;

    logic                           accept;
    logic [TASK_COUNT-1:0][COUNT_WIDTH-1:0] elapsed_sat;
    logic [TASK_COUNT-1:0]          limit_hit;
    logic [SUM_W-1:0]               rst_sum;
    logic [COUNT_WIDTH-1:0]         rst_sat;

    assign req.ready = !res_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;

    for (genvar g = 0; g < TASK_COUNT; g++)
    begin : g_task
        logic [SUM_W-1:0] sum;
        assign sum = SUM_W'(elapsed_reg[g]) + SUM_W'(cfg.tick_period);
        assign elapsed_sat[g] = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
        assign limit_hit[g] = CMP_W'(elapsed_sat[g]) >= CMP_W'(cfg.limit[g]);
    end

    assign rst_sum = SUM_W'(rst_elapsed_reg) + SUM_W'(cfg.tick_period);
    assign rst_sat = (rst_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : rst_sum[COUNT_WIDTH-1:0];

    always_comb
    begin
        mode_next        = mode_reg;
        action_next      = action_reg;
        mark_next        = mark_reg;
        elapsed_next     = elapsed_reg;
        rst_elapsed_next = rst_elapsed_reg;
        trig_write_next  = 1'b0;
        trig_out_next    = '0;
        report_next      = 1'b0;

        if (req.req_type == tas_pkg::REQ_ALIVE)
        begin
            for (int i = 0; i < TASK_COUNT; i++)
            begin
                if (req.task_index == 1'(i))
                begin
                    mark_next[i]    = tas_pkg::MARK_READY;
                    elapsed_next[i] = '0;
                end
            end
        end
        else
        begin
            case (mode_reg)
                tas_pkg::MODE_NORMAL:
                begin
                    trig_write_next = 1'b1;
                    trig_out_next   = cfg.trigger_value;
                    // ascending scan: highest timed-out index sets the action
                    for (int i = 0; i < TASK_COUNT; i++)
                    begin
                        if (mark_reg[i] == tas_pkg::MARK_READY)
                        begin
                            elapsed_next[i] = elapsed_sat[i];
                            if (limit_hit[i])
                            begin
                                mode_next   = tas_pkg::MODE_TIMEOUT;
                                action_next = cfg.action[i];
                                mark_next[i] = tas_pkg::MARK_TIMEOUT;
                            end
                        end
                    end
                end
                tas_pkg::MODE_TIMEOUT:
                begin
                    if (action_reg == tas_pkg::ACT_POWER_RESET)
                    begin
                        report_next     = 1'b1;
                        trig_write_next = 1'b1;
                        mode_next       = tas_pkg::MODE_RESET_EXEC;
                    end
                    else if (action_reg == tas_pkg::ACT_NOTHING)
                    begin
                        mode_next = tas_pkg::MODE_NORMAL;
                    end
                end
                default:
                begin
                    rst_elapsed_next = rst_sat;
                end
            endcase
        end

        mask_next = '0;
        for (int i = 0; i < TASK_COUNT; i++)
        begin
            mask_next[i] = (mark_next[i] == tas_pkg::MARK_TIMEOUT);
        end
    end

    assign res_valid_next = accept || (res_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= tas_pkg::MODE_NORMAL;
            action_reg      <= tas_pkg::ACT_NOTHING;
            mark_reg        <= {TASK_COUNT{tas_pkg::MARK_IDLE}};
            elapsed_reg     <= '0;
            rst_elapsed_reg <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                mode_reg        <= mode_next;
                action_reg      <= action_next;
                mark_reg        <= mark_next;
                elapsed_reg     <= elapsed_next;
                rst_elapsed_reg <= rst_elapsed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            trig_write_reg <= trig_write_next;
            trig_out_reg   <= trig_out_next;
            report_reg     <= report_next;
            mode_out_reg   <= mode_next;
            mask_reg       <= mask_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.trigger_write  = trig_write_reg;
    assign res.trigger_out    = trig_out_reg;
    assign res.timeout_report = report_reg;
    assign res.manager_mode   = mode_out_reg;
    assign res.timed_out_mask = mask_reg;

endmodule

`default_nettype wire
